/* rtl/rdnu_pkg.sv */
// ----------------------------------------------------------------------------
// rdnu_pkg
// Shared types and constants for the RDN value unescaper.
// ----------------------------------------------------------------------------
package rdnu_pkg;

   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_BS    = 2'd1;
   localparam logic [1:0] ESC_HEX   = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       two;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       is_value;
      logic       has_byte;
      logic       last;
      logic       no_separator;
   } entry_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok     = 1'b0;
      h.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.ok     = 1'b1;
         h.nibble = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.ok     = 1'b1;
         h.nibble = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.ok     = 1'b1;
         h.nibble = 4'(c - 8'h37);
      end
      return h;
   endfunction

endpackage

/* rtl/rdnu_front.sv */
// ----------------------------------------------------------------------------
// rdnu_front
// Accepts input bytes, tracks phase and escape state, and queues up to two
// output bytes per input as one entry.
// ----------------------------------------------------------------------------
module rdnu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output logic              push,
   output rdnu_pkg::entry_type push_entry,
   input  logic              queue_full
);

   logic       ivp_ff, ivp_in, ivp_step;
   logic [1:0] esc_ff, esc_in;
   logic [7:0] held_ff, held_in;
   logic [1:0] cnt;
   logic [7:0] b0, b1, plain_b;
   logic       use_plain, accept;
   rdnu_pkg::hex_type hx_c, hx_h;
   logic [7:0] dec;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign hx_c     = rdnu_pkg::hex_decode(in_byte);
   assign hx_h     = rdnu_pkg::hex_decode(held_ff);
   assign dec      = {hx_h.nibble, hx_c.nibble};

   always_comb begin
      ivp_step  = ivp_ff;
      esc_in    = esc_ff;
      held_in   = held_ff;
      cnt       = 2'd0;
      b0        = in_byte;
      b1        = in_byte;
      use_plain = 1'b0;
      plain_b   = in_byte;
      if (!ivp_ff) begin
         if (in_byte == rdnu_pkg::CH_EQ) ivp_step = 1'b1;
         else cnt = 2'd1;
      end else if (esc_ff == rdnu_pkg::ESC_BS) begin
         esc_in = rdnu_pkg::ESC_NONE;
         if (hx_c.ok && !in_last) begin
            held_in = in_byte;
            esc_in  = rdnu_pkg::ESC_HEX;
         end else begin
            cnt = 2'd1;
         end
      end else if (esc_ff == rdnu_pkg::ESC_HEX) begin
         esc_in = rdnu_pkg::ESC_NONE;
         if (hx_c.ok && hx_h.ok) begin
            if (dec == 8'd0) begin
               cnt = 2'd2;
               b0  = held_ff;
            end else begin
               use_plain = 1'b1;
               plain_b   = dec;
            end
         end else begin
            cnt       = 2'd1;
            b0        = held_ff;
            use_plain = 1'b1;
         end
      end else begin
         esc_in    = rdnu_pkg::ESC_NONE;
         use_plain = 1'b1;
      end
      if (use_plain) begin
         if (plain_b == rdnu_pkg::CH_QUOTE) begin
            cnt = cnt;
         end else if (plain_b == rdnu_pkg::CH_BSLASH) begin
            esc_in = rdnu_pkg::ESC_BS;
         end else begin
            if (cnt == 2'd0) b0 = plain_b;
            else b1 = plain_b;
            cnt = cnt + 2'd1;
         end
      end
      ivp_in = ivp_step;
      if (in_last) begin
         ivp_in  = 1'b0;
         esc_in  = rdnu_pkg::ESC_NONE;
         held_in = 8'd0;
      end
   end

   assign push                    = accept && (cnt != 2'd0 || in_last);
   assign push_entry.two          = (cnt == 2'd2);
   assign push_entry.has_byte     = (cnt != 2'd0);
   assign push_entry.byte0        = (cnt != 2'd0) ? b0 : 8'd0;
   assign push_entry.byte1        = b1;
   assign push_entry.is_value     = ivp_step;
   assign push_entry.last         = in_last;
   assign push_entry.no_separator = in_last && !ivp_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         ivp_ff  <= 1'b0;
         esc_ff  <= rdnu_pkg::ESC_NONE;
         held_ff <= 8'd0;
      end else if (accept) begin
         ivp_ff  <= ivp_in;
         esc_ff  <= esc_in;
         held_ff <= held_in;
      end
   end

   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> !ivp_ff && esc_ff == rdnu_pkg::ESC_NONE)
      else $error("state not cleared after final byte");

endmodule

/* rtl/rdnu_queue.sv */
// ----------------------------------------------------------------------------
// rdnu_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module rdnu_queue #(
   parameter int Depth = rdnu_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rdnu_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output rdnu_pkg::entry_type head
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(Depth);

   rdnu_pkg::entry_type mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == DepthCnt);
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("transfer pushed into full queue");

endmodule

/* rtl/rdnu_back.sv */
// ----------------------------------------------------------------------------
// rdnu_back
// Splits queued entries into one or two results and drives the output
// register.
// ----------------------------------------------------------------------------
module rdnu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  rdnu_pkg::entry_type head,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic                out_is_value,
   output logic                out_has_byte,
   output logic                out_last,
   output logic                out_no_separator
);

   logic       valid_ff, valid_in;
   logic       part_ff, part_in;
   logic [7:0] byte_ff, byte_in;
   logic       isv_ff, isv_in, hasb_ff, hasb_in, last_ff, last_in, nosep_ff, nosep_in;
   logic       load, final_part;

   assign load       = !valid_ff || out_ready;
   assign final_part = !head.two || part_ff;
   assign pop        = load && head_valid && final_part;

   always_comb begin
      valid_in = valid_ff;
      part_in  = part_ff;
      byte_in  = byte_ff;
      isv_in   = isv_ff;
      hasb_in  = hasb_ff;
      last_in  = last_ff;
      nosep_in = nosep_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            part_in  = !final_part;
            byte_in  = part_ff ? head.byte1 : head.byte0;
            isv_in   = head.is_value;
            hasb_in  = head.has_byte;
            last_in  = head.last && final_part;
            nosep_in = head.no_separator && final_part;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         part_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         part_ff  <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      isv_ff   <= isv_in;
      hasb_ff  <= hasb_in;
      last_ff  <= last_in;
      nosep_ff <= nosep_in;
   end

   assign out_valid        = valid_ff;
   assign out_byte         = byte_ff;
   assign out_is_value     = isv_ff;
   assign out_has_byte     = hasb_ff;
   assign out_last         = last_ff;
   assign out_no_separator = nosep_ff;

   a_second_half : assert property (@(posedge clock) disable iff (reset)
      part_ff |-> head_valid && head.two)
      else $error("second byte pending without a two-byte entry");

endmodule

/* rtl/rdn_value_unescaper_top.sv */
// ----------------------------------------------------------------------------
// rdn_value_unescaper_top
// Unescapes the value of a relative distinguished name, one byte per transfer.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the queue has room; the front part
// decodes it in that same cycle and queues the resulting bytes. The output
// gives one result per cycle while rsp_tready is high, so an input that yields
// two bytes (an escaped "00" pair, or a held hex digit followed by a plain
// byte) takes two output results, and the input keeps flowing until the entry
// queue of QueueDepth entries fills. Bytes pass the queue, then the output register.
module rdn_value_unescaper_top #(
   parameter int QueueDepth = rdnu_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_byte
   output logic [2:0] rsp_tuser,  // [0] is_value, [1] has_byte, [2] no_separator
   output logic       rsp_tlast
);

   logic                push, pop, queue_full, head_valid;
   rdnu_pkg::entry_type push_entry, head;

   rdnu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   rdnu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   rdnu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_byte         (rsp_tdata),
      .out_is_value     (rsp_tuser[0]),
      .out_has_byte     (rsp_tuser[1]),
      .out_last         (rsp_tlast),
      .out_no_separator (rsp_tuser[2])
   );

endmodule

/* tb/sv/rdn_value_unescaper_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdn_value_unescaper_top_test
// Self-checking bench for the RDN value unescaper.
// ----------------------------------------------------------------------------
// Names are fed a byte at a time over the request stream. A local model of
// the unescape rules (type/value split, quotes, backslash escapes, hex pairs
// fed back through the value rules) predicts the output bytes, which are
// compared in order against the response stream. A short directed set covers
// the corner cases; random names follow, mostly well formed, under three
// back-pressure profiles.
// ----------------------------------------------------------------------------
module rdn_value_unescaper_top_test;

   localparam int QuietLimit = 2000;
   localparam int TailCycles = 2 * rdnu_pkg::QUEUE_DEPTH + 8;

   typedef struct packed {
      logic [7:0] octet;
      logic       is_value;
      logic       has_byte;
      logic       fin;
      logic       no_sep;
   } unescaped_type;

   class unescape_scoreboard;
      logic       in_value;
      logic [1:0] esc;
      logic [7:0] held;
      unescaped_type step_out[$];
      unescaped_type pending_chars[$];
      int         errors;

      function new();
         in_value = 1'b0;
         esc      = rdnu_pkg::ESC_NONE;
         held     = 8'd0;
         errors   = 0;
      endfunction

      function int nibble_of(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         return -1;
      endfunction

      function void emit_char(logic [7:0] c, logic val);
         step_out.push_back('{octet: c, is_value: val, has_byte: 1'b1, fin: 1'b0,
                              no_sep: 1'b0});
      endfunction

      function void plain_char(logic [7:0] c);
         if (c == rdnu_pkg::CH_QUOTE) begin
         end else if (c == rdnu_pkg::CH_BSLASH) begin
            esc = rdnu_pkg::ESC_BS;
         end else begin
            emit_char(c, 1'b1);
         end
      endfunction

      function void accept_char(logic [7:0] c, logic last);
         int         hi;
         int         lo;
         logic [7:0] n;
         step_out.delete();
         if (!in_value) begin
            if (c == rdnu_pkg::CH_EQ) in_value = 1'b1;
            else emit_char(c, 1'b0);
         end else begin
            case (esc)
               rdnu_pkg::ESC_BS: begin
                  esc = rdnu_pkg::ESC_NONE;
                  if (nibble_of(c) >= 0 && !last) begin
                     held = c;
                     esc  = rdnu_pkg::ESC_HEX;
                  end else begin
                     emit_char(c, 1'b1);
                  end
               end
               rdnu_pkg::ESC_HEX: begin
                  hi  = nibble_of(held);
                  lo  = nibble_of(c);
                  esc = rdnu_pkg::ESC_NONE;
                  if (hi >= 0 && lo >= 0) begin
                     n = 8'(hi * 16 + lo);
                     if (n == 8'd0) begin
                        emit_char(held, 1'b1);
                        emit_char(c, 1'b1);
                     end else begin
                        plain_char(n);
                     end
                  end else begin
                     emit_char(held, 1'b1);
                     plain_char(c);
                  end
               end
               default: begin
                  esc = rdnu_pkg::ESC_NONE;
                  plain_char(c);
               end
            endcase
         end
         if (last) begin
            if (step_out.size() == 0)
               step_out.push_back('{octet: 8'd0, is_value: in_value, has_byte: 1'b0,
                                    fin: 1'b0, no_sep: 1'b0});
            step_out[step_out.size() - 1].fin    = 1'b1;
            step_out[step_out.size() - 1].no_sep = !in_value;
            in_value = 1'b0;
            esc      = rdnu_pkg::ESC_NONE;
            held     = 8'd0;
         end
         foreach (step_out[i]) pending_chars.push_back(step_out[i]);
      endfunction

      function void check_char(logic [7:0] data, logic [2:0] user, logic last);
         unescaped_type want;
         unescaped_type got;
         got = '{octet: data, is_value: user[0], has_byte: user[1], fin: last,
                 no_sep: user[2]};
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected response byte=%h is_value=%b has_byte=%b last=%b",
                     $time, data, user[0], user[1], last);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (got.octet !== want.octet) begin
            $display("%0t: byte expected %h actual %h", $time, want.octet, got.octet);
            errors++;
         end
         if (got.is_value !== want.is_value) begin
            $display("%0t: is_value expected %b actual %b", $time, want.is_value, got.is_value);
            errors++;
         end
         if (got.has_byte !== want.has_byte) begin
            $display("%0t: has_byte expected %b actual %b", $time, want.has_byte, got.has_byte);
            errors++;
         end
         if (got.fin !== want.fin) begin
            $display("%0t: last expected %b actual %b", $time, want.fin, got.fin);
            errors++;
         end
         if (got.no_sep !== want.no_sep) begin
            $display("%0t: no_separator expected %b actual %b", $time, want.no_sep,
                     got.no_sep);
            errors++;
         end
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;  // [7:0] in_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [7:0] out_byte
   logic [2:0] rsp_tuser;         // [0] is_value, [1] has_byte, [2] no_separator
   logic       rsp_tlast;

   unescape_scoreboard sb = new();
   logic [7:0] name_buf[$];
   int         send_idle = 0;
   int         recv_idle = 0;
   int         quiet_cycles = 0;

   rdn_value_unescaper_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) rsp_tready = ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_char(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   function logic [7:0] any_char();
      return 8'($urandom_range(1, 255));
   endfunction

   function logic [7:0] type_char();
      logic [7:0] c;
      c = any_char();
      while (c == rdnu_pkg::CH_EQ) c = any_char();
      return c;
   endfunction

   function logic [7:0] hex_char();
      int k;
      k = $urandom_range(0, 21);
      if (k < 10) return 8'("0" + k);
      if (k < 16) return 8'("a" + k - 10);
      return 8'("A" + k - 16);
   endfunction

   function void load_text(string s);
      name_buf.delete();
      for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
   endfunction

   // Mostly well-formed names with random tokens; the rest is raw noise.
   function void make_name();
      int k;
      name_buf.delete();
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1) == 0) name_buf.push_back(type_char());
            else name_buf.push_back(any_char());
         end
         return;
      end
      repeat ($urandom_range(0, 3)) name_buf.push_back(type_char());
      name_buf.push_back(rdnu_pkg::CH_EQ);
      repeat ($urandom_range(0, 5)) begin
         k = $urandom_range(0, 9);
         if (k <= 2) begin
            name_buf.push_back(any_char());
         end else if (k == 3) begin
            name_buf.push_back(rdnu_pkg::CH_QUOTE);
         end else if (k == 4) begin
            name_buf.push_back(rdnu_pkg::CH_BSLASH);
            name_buf.push_back(any_char());
         end else if (k <= 7) begin
            name_buf.push_back(rdnu_pkg::CH_BSLASH);
            case ($urandom_range(0, 5))
               0: begin
                  name_buf.push_back("0");
                  name_buf.push_back("0");
               end
               1: begin
                  name_buf.push_back("5");
                  name_buf.push_back(($urandom_range(1) == 0) ? "c" : "C");
               end
               2: begin
                  name_buf.push_back("2");
                  name_buf.push_back("2");
               end
               default: begin
                  name_buf.push_back(hex_char());
                  name_buf.push_back(hex_char());
               end
            endcase
         end else if (k == 8) begin
            name_buf.push_back(rdnu_pkg::CH_BSLASH);
            name_buf.push_back(hex_char());
            name_buf.push_back(any_char());
         end else begin
            name_buf.push_back(rdnu_pkg::CH_EQ);
         end
      end
      k = $urandom_range(0, 9);
      if (k == 0) begin
         name_buf.push_back(rdnu_pkg::CH_BSLASH);
      end else if (k == 1) begin
         name_buf.push_back(rdnu_pkg::CH_BSLASH);
         name_buf.push_back(hex_char());
      end
   endfunction

   task automatic send_item(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = c;
      req_tlast  = fin;
      do @(posedge clock); while (!req_tready);
      sb.accept_char(c, fin);
      @(negedge clock);
   endtask

   task automatic send_name();
      foreach (name_buf[i]) send_item(name_buf[i], i == name_buf.size() - 1);
   endtask

   // Hold the sender until every predicted byte has been taken.
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input int s_idle, input int r_idle, input int n_items);
      int sent;
      send_idle = s_idle;
      recv_idle = r_idle;
      sent = 0;
      while (sent < n_items) begin
         make_name();
         send_name();
         sent += name_buf.size();
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle = 23;
      recv_idle = 82;

      name_buf = '{8'h01, 8'hFF};
      send_name();
      load_text("=");
      send_name();
      load_text("a=\\00\"\\");
      send_name();
      load_text("=\\5c,\\22\\4z");
      send_name();
      load_text("=\\4");
      send_name();
      load_text("=\\5C");
      send_name();
      drain();

      run_phase(23, 82, 135);
      run_phase(82, 23, 135);
      run_phase(0, 0, 135);

      repeat (TailCycles) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
